@@ sv/lrupr_pkg.sv @@
`default_nettype none

package lrupr_pkg;

    localparam int FRAMES_MAX  = 8;
    localparam int IDX_BITS    = 3;
    localparam int CNT_BITS    = 4;
    localparam int PAGE_BITS   = 8;
    localparam int STAMP_BITS  = 32;
    localparam int FAULT_BITS  = 32;
    localparam int ENTRY_BITS  = PAGE_BITS + STAMP_BITS;

    localparam logic [CNT_BITS-1:0]   FRAMES_RESET = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0]   FRAMES_LIMIT = CNT_BITS'(FRAMES_MAX);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX    = {STAMP_BITS{1'b1}};
    localparam logic [FAULT_BITS-1:0] FAULT_MAX    = {FAULT_BITS{1'b1}};

    typedef struct packed {
        logic [PAGE_BITS-1:0] page_number;
        logic                 sequence_end;
    } in_item_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_BITS-1:0]   frame_index;
        logic                  evicted_valid;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [FAULT_BITS-1:0] fault_total;
        logic                  stamp_saturated;
    } out_item_t;

    // control from the sequencer to the frame store
    typedef struct packed {
        logic                  start;
        logic [PAGE_BITS-1:0]  target_page;
        logic                  rd_en;
        logic [IDX_BITS-1:0]   rd_addr;
        logic                  wr_en;
        logic [IDX_BITS-1:0]   wr_addr;
        logic [PAGE_BITS-1:0]  wr_page;
        logic [STAMP_BITS-1:0] wr_stamp;
    } scan_ctl_t;

    // scan progress and results back to the sequencer
    typedef struct packed {
        logic                 cmp_valid;
        logic [IDX_BITS-1:0]  cmp_idx;
        logic                 found;
        logic [IDX_BITS-1:0]  match_idx;
        logic [IDX_BITS-1:0]  best_idx;
        logic [PAGE_BITS-1:0] best_page;
    } scan_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } lru_state_t;

endpackage

`default_nettype wire

@@ sv/lrupr_frame_store.sv @@
`default_nettype none

module lrupr_frame_store (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire lrupr_pkg::scan_ctl_t ctl,
    output lrupr_pkg::scan_stat_t   stat
);

    // one entry per frame: page number above, use stamp below
    logic [lrupr_pkg::ENTRY_BITS-1:0] mem [lrupr_pkg::FRAMES_MAX];
    logic [lrupr_pkg::ENTRY_BITS-1:0] rdata_reg;

    logic                             rd_valid_reg;
    logic [lrupr_pkg::IDX_BITS-1:0]   rd_idx_reg;
    logic                             found_reg;
    logic                             found_next;
    logic [lrupr_pkg::IDX_BITS-1:0]   match_idx_reg;
    logic [lrupr_pkg::IDX_BITS-1:0]   match_idx_next;
    logic [lrupr_pkg::IDX_BITS-1:0]   best_idx_reg;
    logic [lrupr_pkg::IDX_BITS-1:0]   best_idx_next;
    logic [lrupr_pkg::PAGE_BITS-1:0]  best_page_reg;
    logic [lrupr_pkg::PAGE_BITS-1:0]  best_page_next;
    logic [lrupr_pkg::STAMP_BITS-1:0] best_stamp_reg;
    logic [lrupr_pkg::STAMP_BITS-1:0] best_stamp_next;

    logic [lrupr_pkg::PAGE_BITS-1:0]  cmp_page;
    logic [lrupr_pkg::STAMP_BITS-1:0] cmp_stamp;

    assign cmp_page  = rdata_reg[lrupr_pkg::ENTRY_BITS-1 -: lrupr_pkg::PAGE_BITS];
    assign cmp_stamp = rdata_reg[lrupr_pkg::STAMP_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= {ctl.wr_page, ctl.wr_stamp};
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[ctl.rd_addr];
        end
    end

    // first match wins, strict less-than keeps the lowest index on ties
    always_comb
    begin
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        best_idx_next   = best_idx_reg;
        best_page_next  = best_page_reg;
        best_stamp_next = best_stamp_reg;
        if (ctl.start)
        begin
            found_next = 1'b0;
        end
        else if (rd_valid_reg)
        begin
            if (!found_reg && cmp_page == ctl.target_page)
            begin
                found_next     = 1'b1;
                match_idx_next = rd_idx_reg;
            end
            if (rd_idx_reg == '0 || cmp_stamp < best_stamp_reg)
            begin
                best_idx_next   = rd_idx_reg;
                best_page_next  = cmp_page;
                best_stamp_next = cmp_stamp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctl.rd_en;
            rd_idx_reg   <= ctl.rd_addr;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg  <= match_idx_next;
        best_idx_reg   <= best_idx_next;
        best_page_reg  <= best_page_next;
        best_stamp_reg <= best_stamp_next;
    end

    assign stat.cmp_valid = rd_valid_reg;
    assign stat.cmp_idx   = rd_idx_reg;
    assign stat.found     = found_reg;
    assign stat.match_idx = match_idx_reg;
    assign stat.best_idx  = best_idx_reg;
    assign stat.best_page = best_page_reg;

endmodule

`default_nettype wire

@@ sv/lru_page_replacement.sv @@
`default_nettype none

// LRU page replacement: each input transfer carries one page reference and produces exactly
// one result transfer telling whether the page was resident, which frame now holds it, which
// page (if any) was evicted, the running fault count and whether the use-stamp counter has
// saturated. Frames live in a small synchronous memory that is scanned one entry per cycle
// over the filled frames (1 to frames_in_use, at most 8), through the single read port of the
// frame store; an empty store is not scanned. A new reference is taken the cycle after the
// previous result is loaded into the output register. A finished result may sit in the
// output register while the next reference is taken and scanned; that reference's result
// then waits until the output register is free.
// Writing frames_in_use (0 reads as 1, above 8 reads as 8) empties the store; a reference
// with sequence_end set does the same after its result is produced.

module lru_page_replacement (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire lrupr_pkg::in_item_t    in_data,
    output logic                        out_valid,
    input  wire                         out_ready,
    output lrupr_pkg::out_item_t        out_data,
    input  wire                         cfg_we,
    input  wire  [lrupr_pkg::CNT_BITS-1:0] cfg_data
);

    lrupr_pkg::lru_state_t            state_reg, state_next;

    // configuration and sequence state
    logic [lrupr_pkg::CNT_BITS-1:0]   frames_reg, frames_next;
    logic [lrupr_pkg::CNT_BITS-1:0]   filled_reg, filled_next;
    logic [lrupr_pkg::STAMP_BITS-1:0] stamp_reg, stamp_next;
    logic [lrupr_pkg::FAULT_BITS-1:0] fault_reg, fault_next;

    // the reference being worked on
    logic [lrupr_pkg::PAGE_BITS-1:0]  page_reg, page_next;
    logic                             last_reg, last_next;
    logic [lrupr_pkg::CNT_BITS-1:0]   used_reg, used_next;
    logic [lrupr_pkg::CNT_BITS-1:0]   issue_reg, issue_next;

    // output register
    logic                             out_valid_reg, out_valid_next;
    lrupr_pkg::out_item_t             out_data_reg, out_data_next;

    lrupr_pkg::scan_ctl_t             ctl;
    lrupr_pkg::scan_stat_t            stat;

    logic [lrupr_pkg::CNT_BITS-1:0]   limit;
    logic [lrupr_pkg::CNT_BITS-1:0]   used_now;
    logic [lrupr_pkg::CNT_BITS-1:0]   last_issue;
    logic                             store_full;
    logic [lrupr_pkg::IDX_BITS-1:0]   slot;
    logic                             out_free;

    lrupr_frame_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .stat  (stat)
    );

    // managed frame count: zero behaves as one, anything past the store depth as the depth
    always_comb
    begin
        if (frames_reg == '0)
        begin
            limit = lrupr_pkg::CNT_BITS'(1);
        end
        else if (frames_reg > lrupr_pkg::FRAMES_LIMIT)
        begin
            limit = lrupr_pkg::FRAMES_LIMIT;
        end
        else
        begin
            limit = frames_reg;
        end
        used_now = (filled_reg > limit) ? limit : filled_reg;
    end

    assign last_issue = used_reg - lrupr_pkg::CNT_BITS'(1);
    assign store_full = (used_reg == limit);
    assign out_free   = !out_valid_reg || out_ready;

    // frame chosen for this reference: the hit, the next empty frame or the oldest one
    always_comb
    begin
        if (stat.found)
        begin
            slot = stat.match_idx;
        end
        else if (!store_full)
        begin
            slot = used_reg[lrupr_pkg::IDX_BITS-1:0];
        end
        else
        begin
            slot = stat.best_idx;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        frames_next    = frames_reg;
        filled_next    = filled_reg;
        stamp_next     = stamp_reg;
        fault_next     = fault_reg;
        page_next      = page_reg;
        last_next      = last_reg;
        used_next      = used_reg;
        issue_next     = issue_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_ready       = 1'b0;

        ctl             = '0;
        ctl.target_page = page_reg;
        ctl.rd_addr     = issue_reg[lrupr_pkg::IDX_BITS-1:0];
        ctl.wr_addr     = slot;
        ctl.wr_page     = page_reg;
        ctl.wr_stamp    = stamp_reg;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lrupr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    page_next  = in_data.page_number;
                    last_next  = in_data.sequence_end;
                    used_next  = used_now;
                    issue_next = '0;
                    if (stamp_reg != lrupr_pkg::STAMP_MAX)
                    begin
                        stamp_next = stamp_reg + lrupr_pkg::STAMP_BITS'(1);
                    end
                    state_next = (used_now == '0) ? lrupr_pkg::ST_DONE : lrupr_pkg::ST_SCAN;
                end
            end

            lrupr_pkg::ST_SCAN:
            begin
                // one frame read per cycle, compared the cycle after
                if (issue_reg < used_reg)
                begin
                    ctl.rd_en  = 1'b1;
                    issue_next = issue_reg + lrupr_pkg::CNT_BITS'(1);
                end
                if (stat.cmp_valid && {1'b0, stat.cmp_idx} == last_issue)
                begin
                    state_next = lrupr_pkg::ST_DONE;
                end
            end

            lrupr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.wr_en      = 1'b1;
                    out_valid_next = 1'b1;

                    out_data_next.hit             = stat.found;
                    out_data_next.frame_index     = slot;
                    out_data_next.evicted_valid   = !stat.found && store_full;
                    out_data_next.evicted_page    = (!stat.found && store_full) ?
                                                    stat.best_page : '0;
                    out_data_next.stamp_saturated = (stamp_reg == lrupr_pkg::STAMP_MAX);
                    out_data_next.fault_total     = fault_reg;

                    if (!stat.found)
                    begin
                        if (!store_full)
                        begin
                            filled_next = used_reg + lrupr_pkg::CNT_BITS'(1);
                        end
                        if (fault_reg != lrupr_pkg::FAULT_MAX)
                        begin
                            fault_next = fault_reg + lrupr_pkg::FAULT_BITS'(1);
                            out_data_next.fault_total = fault_next;
                        end
                    end

                    // end of sequence empties everything after the result
                    if (last_reg)
                    begin
                        filled_next = '0;
                        stamp_next  = '0;
                        fault_next  = '0;
                    end
                    state_next = lrupr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lrupr_pkg::ST_IDLE;
            end
        endcase

        // register write, which the user must make only while idle, unchecked by the block; empties the store as well
        if (cfg_we)
        begin
            frames_next = cfg_data;
            filled_next = '0;
            stamp_next  = '0;
            fault_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrupr_pkg::ST_IDLE;
            frames_reg    <= lrupr_pkg::FRAMES_RESET;
            filled_reg    <= '0;
            stamp_reg     <= '0;
            fault_reg     <= '0;
            used_reg      <= '0;
            issue_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frames_reg    <= frames_next;
            filled_reg    <= filled_next;
            stamp_reg     <= stamp_next;
            fault_reg     <= fault_next;
            used_reg      <= used_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg     <= page_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ sim/lru_page_replacement_test.sv @@
`timescale 1ns / 100ps

module lru_page_replacement_test;

    // kinds of row in the directed table
    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    // one directed row: a page reference or a frame-count write;
    // typed rows carry the result read straight off the rules
    typedef struct {
        row_kind_t kind;
        logic [7:0] value;
        logic last;
        bit typed;
        lrupr_pkg::out_item_t want;
    } dir_row_t;

    localparam int DIR_COUNT = 31;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 85;
    localparam int LONG_STALL_AT = 400;
    localparam int LONG_STALL_CYCLES = 250;
    // covers a scan of up to eight frames, with margin
    localparam int DRAIN_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    lrupr_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    lrupr_pkg::out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [lrupr_pkg::CNT_BITS-1:0] cfg_data = '0;

    // shadow copy of the frame store and counters
    logic [lrupr_pkg::CNT_BITS-1:0] frames_reg;
    logic [lrupr_pkg::PAGE_BITS-1:0] shadow_page [lrupr_pkg::FRAMES_MAX];
    logic [lrupr_pkg::STAMP_BITS-1:0] shadow_stamp [lrupr_pkg::FRAMES_MAX];
    int unsigned shadow_fill;
    logic [lrupr_pkg::STAMP_BITS-1:0] shadow_clock;
    logic [lrupr_pkg::FAULT_BITS-1:0] shadow_faults;

    // results still owed by the block, oldest first
    lrupr_pkg::out_item_t pending_results [$];

    int mismatches = 0;
    int results_seen = 0;
    int refs_sent = 0;
    int hits_seen = 0;
    int evictions_seen = 0;
    int seq_ends = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    bit long_stall_done = 1'b0;

    // directed table: reset default of three frames first, then the
    // zero count (treated as one), an oversize count (treated as eight),
    // the full eight and the single frame
    dir_row_t dir_rows [DIR_COUNT] = '{
        '{ROW_REF, 8'd0,   1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   32'd1, 1'b0}},
        '{ROW_REF, 8'd255, 1'b0, 1'b1, '{1'b0, 3'd1, 1'b0, 8'd0,   32'd2, 1'b0}},
        '{ROW_REF, 8'd0,   1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   32'd2, 1'b0}},
        '{ROW_REF, 8'd7,   1'b0, 1'b1, '{1'b0, 3'd2, 1'b0, 8'd0,   32'd3, 1'b0}},
        '{ROW_REF, 8'd9,   1'b0, 1'b1, '{1'b0, 3'd1, 1'b1, 8'd255, 32'd4, 1'b0}},
        '{ROW_REF, 8'd255, 1'b1, 1'b1, '{1'b0, 3'd0, 1'b1, 8'd0,   32'd5, 1'b0}},
        '{ROW_REF, 8'd255, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   32'd1, 1'b0}},
        '{ROW_CFG, 8'd0,   1'b0, 1'b0, '0},
        '{ROW_REF, 8'd5,   1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   32'd1, 1'b0}},
        '{ROW_REF, 8'd6,   1'b0, 1'b1, '{1'b0, 3'd0, 1'b1, 8'd5,   32'd2, 1'b0}},
        '{ROW_REF, 8'd6,   1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   32'd2, 1'b0}},
        '{ROW_CFG, 8'd15,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd10,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd20,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd30,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd40,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd50,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd60,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd70,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd80,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd90,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd10,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd80,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'd170, 1'b1, 1'b0, '0},
        '{ROW_CFG, 8'd8,   1'b0, 1'b0, '0},
        '{ROW_REF, 8'h55,  1'b0, 1'b0, '0},
        '{ROW_REF, 8'hAA,  1'b1, 1'b0, '0},
        '{ROW_CFG, 8'd1,   1'b0, 1'b0, '0},
        '{ROW_REF, 8'd1,   1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   32'd1, 1'b0}},
        '{ROW_REF, 8'd1,   1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   32'd1, 1'b0}},
        '{ROW_REF, 8'd2,   1'b1, 1'b1, '{1'b0, 3'd0, 1'b1, 8'd1,   32'd2, 1'b0}}
    };

    // frame counts per random phase; a negative entry picks one at random
    int phase_frames [PHASES] = '{1, 8, 0, 15, 2, -1, 6, -1, 4, -1};

    lru_page_replacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // empties the shadow store, as a frame-count write or sequence end does
    function automatic void clear_shadow();
        for (int i = 0; i < lrupr_pkg::FRAMES_MAX; i++)
        begin
            shadow_page[i] = '0;
            shadow_stamp[i] = '0;
        end
        shadow_fill = 0;
        shadow_clock = '0;
        shadow_faults = '0;
    endfunction

    // zero counts as one frame, anything above eight as eight
    function automatic int unsigned frames_managed();
        if (frames_reg == 0)
            return 1;
        if (frames_reg > lrupr_pkg::FRAMES_LIMIT)
            return lrupr_pkg::FRAMES_MAX;
        return frames_reg;
    endfunction

    // looks one reference up in the shadow store and updates it, returning
    // the result the block owes for it
    function automatic lrupr_pkg::out_item_t lru_lookup(lrupr_pkg::in_item_t req);
        lrupr_pkg::out_item_t res;
        int unsigned lim;
        int unsigned used;
        int unsigned slot;
        bit found;
        logic [lrupr_pkg::STAMP_BITS-1:0] oldest;
        lim = frames_managed();
        used = (shadow_fill > lim) ? lim : shadow_fill;
        slot = 0;
        found = 1'b0;
        res = '0;
        // the stamp clock advances on every reference and sticks at its top
        if (shadow_clock != lrupr_pkg::STAMP_MAX)
            shadow_clock = shadow_clock + 1'b1;
        for (int i = 0; i < used; i++)
        begin
            if (!found && shadow_page[i] == req.page_number)
            begin
                slot = i;
                found = 1'b1;
            end
        end
        if (found)
            shadow_stamp[slot] = shadow_clock;
        else
        begin
            if (used < lim)
            begin
                slot = used;
                shadow_fill = used + 1;
            end
            else
            begin
                // least recently used frame; strict compare keeps the lowest index on ties
                oldest = shadow_stamp[0];
                for (int i = 1; i < lim; i++)
                begin
                    if (shadow_stamp[i] < oldest)
                    begin
                        oldest = shadow_stamp[i];
                        slot = i;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page = shadow_page[slot];
            end
            shadow_page[slot] = req.page_number;
            shadow_stamp[slot] = shadow_clock;
            if (shadow_faults != lrupr_pkg::FAULT_MAX)
                shadow_faults = shadow_faults + 1'b1;
        end
        res.hit = found;
        res.frame_index = slot[lrupr_pkg::IDX_BITS-1:0];
        res.fault_total = shadow_faults;
        res.stamp_saturated = (shadow_clock == lrupr_pkg::STAMP_MAX);
        if (req.sequence_end)
            clear_shadow();
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // offers one reference and holds it until the transfer, then predicts
    task automatic send_ref(logic [7:0] page, logic last, bit typed,
                            lrupr_pkg::out_item_t want);
        lrupr_pkg::in_item_t req;
        lrupr_pkg::out_item_t guess;
        req.page_number = page;
        req.sequence_end = last;
        @(negedge clk);
        in_valid = 1'b1;
        in_data = req;
        do @(posedge clk); while (!in_ready);
        guess = lru_lookup(req);
        pending_results.push_back(typed ? want : guess);
        refs_sent++;
        if (last)
            seq_ends++;
    endtask

    // bursts of back-to-back offers with random gaps between them;
    // now and then a long burst with no gap at all
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 15);
        end
    endtask

    // frame-count write, only once every result is home and the scan has drained
    task automatic write_frames(logic [lrupr_pkg::CNT_BITS-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        frames_reg = value;
        clear_shadow();
        cfg_writes++;
    endtask

    // receiver: ready pattern changes mode every so often; once, after
    // enough results, it holds off long enough for the block to back up
    // and drop in_ready while the sender keeps offering
    initial
    begin
        int mode;
        int mode_left;
        int stall_left;
        mode = 0;
        mode_left = 0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!long_stall_done && results_seen >= LONG_STALL_AT)
            begin
                long_stall_done = 1'b1;
                stall_left = LONG_STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    2: out_ready = ($urandom_range(0, 3) == 0);
                    default: out_ready = ~out_ready;
                endcase
            end
        end
    end

    // result side: every transfer out is matched against the oldest expectation
    always @(posedge clk)
    begin
        lrupr_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          results_seen));
            else
            begin
                want = pending_results.pop_front();
                if (out_data.hit !== want.hit)
                    report_mismatch($sformatf("result %0d hit %b expected %b",
                                              results_seen, out_data.hit, want.hit));
                if (out_data.frame_index !== want.frame_index)
                    report_mismatch($sformatf("result %0d frame_index %0d expected %0d",
                                              results_seen, out_data.frame_index,
                                              want.frame_index));
                if (out_data.evicted_valid !== want.evicted_valid)
                    report_mismatch($sformatf("result %0d evicted_valid %b expected %b",
                                              results_seen, out_data.evicted_valid,
                                              want.evicted_valid));
                if (out_data.evicted_page !== want.evicted_page)
                    report_mismatch($sformatf("result %0d evicted_page %0d expected %0d",
                                              results_seen, out_data.evicted_page,
                                              want.evicted_page));
                if (out_data.fault_total !== want.fault_total)
                    report_mismatch($sformatf("result %0d fault_total %0d expected %0d",
                                              results_seen, out_data.fault_total,
                                              want.fault_total));
                if (out_data.stamp_saturated !== want.stamp_saturated)
                    report_mismatch($sformatf("result %0d stamp_saturated %b expected %b",
                                              results_seen, out_data.stamp_saturated,
                                              want.stamp_saturated));
                if (want.hit)
                    hits_seen++;
                if (want.evicted_valid)
                    evictions_seen++;
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("run timed out with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [lrupr_pkg::PAGE_BITS-1:0] pool [16];
        int pool_size;
        int lim;
        int fr;
        logic [7:0] page;
        logic last;
        frames_reg = lrupr_pkg::FRAMES_RESET;
        clear_shadow();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed part
        for (int r = 0; r < DIR_COUNT; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_frames(dir_rows[r].value[lrupr_pkg::CNT_BITS-1:0]);
            else
            begin
                send_ref(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                         dir_rows[r].want);
                pace_sender();
            end
        end

        // random part: mostly references drawn from a small working set a
        // little larger than the frame count, so hits and evictions mix,
        // with stray pages and the odd sequence end thrown in
        for (int ph = 0; ph < PHASES; ph++)
        begin
            fr = (phase_frames[ph] < 0) ? $urandom_range(0, 15) : phase_frames[ph];
            write_frames(fr[lrupr_pkg::CNT_BITS-1:0]);
            lim = frames_managed();
            pool_size = $urandom_range(lim + 1, 2 * lim + 1);
            if (pool_size > 16)
                pool_size = 16;
            for (int i = 0; i < pool_size; i++)
                pool[i] = lrupr_pkg::PAGE_BITS'($urandom_range(0, 255));
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    page = pool[$urandom_range(0, pool_size - 1)];
                else
                    page = 8'($urandom_range(0, 255));
                last = ($urandom_range(0, 39) == 0);
                send_ref(page, last, 1'b0, '0);
                pace_sender();
            end
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES * 2) @(posedge clk);

        $display("covered %0d references: %0d hits, %0d evictions, %0d sequence ends",
                 refs_sent, hits_seen, evictions_seen, seq_ends);
        $display("over %0d frame-count writes, with one long output stall of %0d cycles",
                 cfg_writes, LONG_STALL_CYCLES);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
